### sv/ffua_pkg.sv
package ffua_pkg;

  localparam int unsigned OP_W        = 2;
  localparam int unsigned ID_W        = 8;
  localparam int unsigned LEN_W       = 7;
  localparam int unsigned STATUS_W    = 3;
  localparam int unsigned MAX_RESULTS = 64;

  typedef enum logic [OP_W-1:0] {
    OP_CREATE = 2'd0,
    OP_DELETE = 2'd1,
    OP_PRINT  = 2'd2
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_CREATED = 3'd0,
    ST_NO_MEM  = 3'd1,
    ST_DELETED = 3'd2,
    ST_NO_PROC = 3'd3,
    ST_LAYOUT  = 3'd4
  } status_e;

endpackage

### sv/first_fit_unit_allocator_unit.sv
// Each operation scans the owner map one unit a cycle through a single-read-port memory.
// Create: scans for the first free run that fits, then stamps the found run unit by unit.
// Delete: frees the first run owned by the id. Print: one result per run, at most MAX_RESULTS.
// Create or delete with id zero, and create with size zero, answer in the next cycle without a scan.
// Reset clears the owner map in a sweep, with busy_o high until the sweep ends.
// Results appear for one cycle on valid_o; the receiver cannot stall them.
module first_fit_unit_allocator_unit #(
  parameter int unsigned POOL_UNITS = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [ffua_pkg::OP_W-1:0]     op_i,
  input  logic [ffua_pkg::ID_W-1:0]     proc_id_i,
  input  logic [ffua_pkg::LEN_W-1:0]    size_i,
  output logic                          valid_o,
  output logic [ffua_pkg::STATUS_W-1:0] status_o,
  output logic [ffua_pkg::ID_W-1:0]     owner_o,
  output logic [ffua_pkg::LEN_W-1:0]    length_o,
  output logic                          last_o
);
  import ffua_pkg::*;

  localparam int unsigned IDX_W = $clog2(POOL_UNITS);
  localparam int unsigned CNT_W = $clog2(POOL_UNITS + 1);
  localparam int unsigned CMP_W = (CNT_W > LEN_W) ? CNT_W : LEN_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(POOL_UNITS - 1);
  localparam logic [LEN_W-1:0] LAST_RES = LEN_W'(MAX_RESULTS - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FILL,
    S_TAIL
  } state_e;

  state_e           state_q;
  op_e              op_q;
  logic [ID_W-1:0]  id_q;
  logic [LEN_W-1:0] size_q;
  logic [IDX_W-1:0] rd_idx_q;
  logic             rd_end_q;
  logic             dv_q;
  logic [IDX_W-1:0] didx_q;
  logic [CNT_W-1:0] run_q;
  logic [IDX_W-1:0] start_q;
  logic [CNT_W-1:0] cnt_q;
  logic [ID_W-1:0]  cur_q;
  logic [LEN_W-1:0] nres_q;
  logic [IDX_W-1:0] wr_q;
  logic [IDX_W-1:0] end_q;

  logic             valid_q;
  status_e          status_q;
  logic [ID_W-1:0]  owner_q;
  logic [LEN_W-1:0] len_q;
  logic             last_q;

  logic             map_ready;
  logic [ID_W-1:0]  rdata;
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  logic [ID_W-1:0]  mem_wdata;

  logic             accept;
  logic             is_last;
  logic             unit_free;
  logic             id_match;
  logic [CNT_W-1:0] run_d;
  logic [IDX_W-1:0] start_d;
  logic             fit;
  logic [CNT_W-1:0] cnt_d;

  ffua_map #(
    .DEPTH (POOL_UNITS),
    .IDX_W (IDX_W)
  ) u_map (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (rd_idx_q),
    .rdata_o (rdata),
    .ready_o (map_ready)
  );

  assign busy_o = (state_q != S_IDLE) || !map_ready;
  assign accept = start_i && !busy_o;

  assign is_last   = (didx_q == LAST_IDX);
  assign unit_free = (rdata == '0);
  assign id_match  = (rdata == id_q);
  assign run_d     = unit_free ? run_q + CNT_W'(1) : '0;
  assign start_d   = unit_free ? start_q : didx_q + IDX_W'(1);
  assign fit       = CMP_W'(run_d) >= CMP_W'(size_q);
  assign cnt_d     = id_match ? cnt_q + CNT_W'(1) : cnt_q;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = didx_q;
    mem_wdata = '0;
    if (state_q == S_SCAN && dv_q && op_q == OP_DELETE && id_match) begin
      mem_we = 1'b1;
    end else if (state_q == S_FILL) begin
      mem_we    = 1'b1;
      mem_waddr = wr_q;
      mem_wdata = id_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      op_q     <= OP_CREATE;
      id_q     <= '0;
      size_q   <= '0;
      rd_idx_q <= '0;
      rd_end_q <= 1'b0;
      dv_q     <= 1'b0;
      didx_q   <= '0;
      run_q    <= '0;
      start_q  <= '0;
      cnt_q    <= '0;
      cur_q    <= '0;
      nres_q   <= '0;
      wr_q     <= '0;
      end_q    <= '0;
      valid_q  <= 1'b0;
      status_q <= ST_CREATED;
      owner_q  <= '0;
      len_q    <= '0;
      last_q   <= 1'b0;
    end else begin
      valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            op_q     <= op_e'(op_i);
            id_q     <= proc_id_i;
            size_q   <= size_i;
            rd_idx_q <= '0;
            rd_end_q <= 1'b0;
            dv_q     <= 1'b0;
            run_q    <= '0;
            start_q  <= '0;
            cnt_q    <= '0;
            nres_q   <= '0;
            case (op_i)
              OP_CREATE: begin
                if (proc_id_i == '0 || size_i == '0) begin
                  valid_q  <= 1'b1;
                  status_q <= ST_NO_MEM;
                  owner_q  <= proc_id_i;
                  len_q    <= size_i;
                  last_q   <= 1'b1;
                end else begin
                  state_q <= S_SCAN;
                end
              end
              OP_DELETE: begin
                if (proc_id_i == '0) begin
                  valid_q  <= 1'b1;
                  status_q <= ST_NO_PROC;
                  owner_q  <= proc_id_i;
                  len_q    <= '0;
                  last_q   <= 1'b1;
                end else begin
                  state_q <= S_SCAN;
                end
              end
              OP_PRINT: begin
                state_q <= S_SCAN;
              end
              default: begin
                state_q <= S_IDLE;
              end
            endcase
          end
        end

        S_SCAN: begin
          // Issue reads ahead; read data arrives in the next cycle, together with its index in didx_q.
          dv_q   <= !rd_end_q;
          didx_q <= rd_idx_q;
          if (!rd_end_q) begin
            if (rd_idx_q == LAST_IDX) begin
              rd_end_q <= 1'b1;
            end else begin
              rd_idx_q <= rd_idx_q + IDX_W'(1);
            end
          end
          if (dv_q) begin
            case (op_q)
              OP_CREATE: begin
                run_q   <= run_d;
                start_q <= start_d;
                if (fit) begin
                  wr_q    <= start_d;
                  end_q   <= didx_q;
                  state_q <= S_FILL;
                end else if (is_last) begin
                  valid_q  <= 1'b1;
                  status_q <= ST_NO_MEM;
                  owner_q  <= id_q;
                  len_q    <= size_q;
                  last_q   <= 1'b1;
                  state_q  <= S_IDLE;
                end
              end
              OP_DELETE: begin
                cnt_q <= cnt_d;
                // Stop at the first unit past the owned run, or at the pool end.
                if ((!id_match && cnt_q != '0) || is_last) begin
                  valid_q  <= 1'b1;
                  status_q <= (cnt_d == '0) ? ST_NO_PROC : ST_DELETED;
                  owner_q  <= id_q;
                  len_q    <= LEN_W'(cnt_d);
                  last_q   <= 1'b1;
                  state_q  <= S_IDLE;
                end
              end
              OP_PRINT: begin
                if (didx_q == '0 || rdata == cur_q) begin
                  cur_q <= rdata;
                  cnt_q <= (didx_q == '0) ? CNT_W'(1) : cnt_q + CNT_W'(1);
                  if (is_last) begin
                    state_q <= S_TAIL;
                  end
                end else begin
                  valid_q  <= 1'b1;
                  status_q <= ST_LAYOUT;
                  owner_q  <= cur_q;
                  len_q    <= LEN_W'(cnt_q);
                  last_q   <= (nres_q == LAST_RES);
                  nres_q   <= nres_q + LEN_W'(1);
                  cur_q    <= rdata;
                  cnt_q    <= CNT_W'(1);
                  if (nres_q == LAST_RES) begin
                    state_q <= S_IDLE;
                  end else if (is_last) begin
                    state_q <= S_TAIL;
                  end
                end
              end
              default: begin
                state_q <= S_IDLE;
              end
            endcase
          end
        end

        S_FILL: begin
          if (wr_q == end_q) begin
            valid_q  <= 1'b1;
            status_q <= ST_CREATED;
            owner_q  <= id_q;
            len_q    <= size_q;
            last_q   <= 1'b1;
            state_q  <= S_IDLE;
          end else begin
            wr_q <= wr_q + IDX_W'(1);
          end
        end

        S_TAIL: begin
          // Flush the run still open at the pool end.
          valid_q  <= 1'b1;
          status_q <= ST_LAYOUT;
          owner_q  <= cur_q;
          len_q    <= LEN_W'(cnt_q);
          last_q   <= 1'b1;
          state_q  <= S_IDLE;
        end

        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign valid_o  = valid_q;
  assign status_o = status_q;
  assign owner_o  = owner_q;
  assign length_o = len_q;
  assign last_o   = last_q;

`ifndef ASSERT_OFF
  a_single_beat_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && status_o != ST_LAYOUT |-> last_o)
    else $error("non-layout result without last");

  a_last_frees_unit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && last_o |-> !busy_o)
    else $error("block still busy after final result");

  a_zero_id_create: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && op_i == OP_CREATE && proc_id_i == '0
    |=> valid_o && status_o == ST_NO_MEM)
    else $error("create with id zero not rejected at once");

  a_no_result_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !map_ready |-> !valid_o)
    else $error("result during map clearing");
`endif

endmodule

### sv/ffua_map.sv
module ffua_map #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned IDX_W = 6
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     we_i,
  input  logic [IDX_W-1:0]         waddr_i,
  input  logic [ffua_pkg::ID_W-1:0] wdata_i,
  input  logic [IDX_W-1:0]         raddr_i,
  output logic [ffua_pkg::ID_W-1:0] rdata_o,
  output logic                     ready_o
);
  import ffua_pkg::*;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

  logic [ID_W-1:0]  mem [DEPTH];
  logic [ID_W-1:0]  rdata_q;
  logic [IDX_W-1:0] clr_q;
  logic             ready_q;

  // Sweep the map to zero after reset, one entry a cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q   <= '0;
      ready_q <= 1'b0;
    end else if (!ready_q) begin
      if (clr_q == LAST_IDX) begin
        ready_q <= 1'b1;
      end else begin
        clr_q <= clr_q + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!ready_q) begin
      mem[clr_q] <= '0;
    end else if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;
  assign ready_o = ready_q;

endmodule

### tb/first_fit_unit_allocator_unit_tb.sv
`timescale 1ns / 1ps

module first_fit_unit_allocator_unit_tb;
  import ffua_pkg::*;

  localparam int unsigned POOL = 64;
  localparam logic [OP_W-1:0] OP_IGNORED = 2'd3;

  typedef struct packed {
    status_e          status;
    logic [ID_W-1:0]  owner;
    logic [LEN_W-1:0] length;
    logic             last;
  } reply_t;

  class alloc_checker;
    bit [ID_W-1:0] unit_owner [POOL];
    reply_t        pending[$];
    int            errors;

    function void push(status_e st, logic [ID_W-1:0] own, int unsigned len, logic lst);
      reply_t r;
      r.status = st;
      r.owner  = own;
      r.length = len[LEN_W-1:0];
      r.last   = lst;
      pending.push_back(r);
    endfunction

    // Update the owner map for an accepted command and queue its replies.
    function void note_cmd(logic [OP_W-1:0] op, logic [ID_W-1:0] id,
                           logic [LEN_W-1:0] size);
      int unsigned   run;
      int unsigned   first;
      int unsigned   freed;
      int unsigned   count;
      int unsigned   runs;
      bit            placed;
      bit [ID_W-1:0] cur;
      case (op)
        OP_CREATE: begin
          placed = 1'b0;
          if (id != '0 && size != '0) begin
            run   = 0;
            first = 0;
            for (int i = 0; i < POOL && !placed; i++) begin
              if (unit_owner[i] == '0) begin
                run++;
              end else begin
                run   = 0;
                first = i + 1;
              end
              if (run >= 32'(size)) begin
                for (int j = first; j <= i; j++) unit_owner[j] = id;
                placed = 1'b1;
              end
            end
          end
          push(placed ? ST_CREATED : ST_NO_MEM, id, 32'(size), 1'b1);
        end
        OP_DELETE: begin
          freed = 0;
          if (id != '0) begin
            for (int i = 0; i < POOL; i++) begin
              if (unit_owner[i] == id) begin
                unit_owner[i] = '0;
                freed++;
              end else if (freed != 0) begin
                break;
              end
            end
          end
          push(freed == 0 ? ST_NO_PROC : ST_DELETED, id, freed, 1'b1);
        end
        OP_PRINT: begin
          cur   = unit_owner[0];
          count = 0;
          runs  = 0;
          for (int i = 0; i < POOL; i++) begin
            if (unit_owner[i] == cur) begin
              count++;
            end else begin
              push(ST_LAYOUT, cur, count, 1'b0);
              runs++;
              // cap the listing; the final kept run carries the last flag
              if (runs == MAX_RESULTS) begin
                pending[pending.size()-1].last = 1'b1;
                return;
              end
              cur   = unit_owner[i];
              count = 1;
            end
          end
          push(ST_LAYOUT, cur, count, 1'b1);
        end
        default: ;
      endcase
    endfunction

    function void check_reply(reply_t got);
      reply_t want;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected beat: status %0d owner %0d length %0d last %0d",
                   got.status, got.owner, got.length, got.last);
        return;
      end
      want = pending.pop_front();
      if (got.status !== want.status || got.owner !== want.owner ||
          got.length !== want.length || got.last !== want.last) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: expected status %0d owner %0d length %0d last %0d, ",
                   want.status, want.owner, want.length, want.last,
                   "got status %0d owner %0d length %0d last %0d",
                   got.status, got.owner, got.length, got.last);
      end
    endfunction
  endclass

  logic              clk_i;
  logic              rst_ni;
  logic              start_i;
  logic              busy_o;
  logic [OP_W-1:0]   op_i;
  logic [ID_W-1:0]   proc_id_i;
  logic [LEN_W-1:0]  size_i;
  logic              valid_o;
  logic [STATUS_W-1:0] status_o;
  logic [ID_W-1:0]   owner_o;
  logic [LEN_W-1:0]  length_o;
  logic              last_o;

  alloc_checker      sb;
  int                burst_left;
  bit [ID_W-1:0]     id_pool [12];

  first_fit_unit_allocator_unit #(
    .POOL_UNITS(POOL)
  ) dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start_i),
    .busy_o    (busy_o),
    .op_i      (op_i),
    .proc_id_i (proc_id_i),
    .size_i    (size_i),
    .valid_o   (valid_o),
    .status_o  (status_o),
    .owner_o   (owner_o),
    .length_o  (length_o),
    .last_o    (last_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  always @(posedge clk_i) begin
    if (rst_ni && valid_o)
      sb.check_reply('{status_e'(status_o), owner_o, length_o, last_o});
  end

  // Hold start until the command is taken; lower it only when a burst ends.
  task automatic send_cmd(logic [OP_W-1:0] op, logic [ID_W-1:0] id,
                          logic [LEN_W-1:0] size);
    int unsigned gap;
    start_i   <= 1'b1;
    op_i      <= op;
    proc_id_i <= id;
    size_i    <= size;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    sb.note_cmd(op, id, size);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        start_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(0, 7);
    end
  endtask

  function automatic logic [ID_W-1:0] pick_id();
    if ($urandom_range(0, 99) < 8) return ID_W'($urandom_range(0, 255));
    return id_pool[4'($urandom_range(0, 11))];
  endfunction

  initial begin
    int unsigned      sent;
    int unsigned      pick;
    logic [LEN_W-1:0] sz;
    sb         = new();
    burst_left = 0;
    rst_ni    <= 1'b0;
    start_i   <= 1'b0;
    op_i      <= OP_CREATE;
    proc_id_i <= '0;
    size_i    <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_cmd(OP_PRINT, 8'd0, 7'd0);
    send_cmd(OP_DELETE, 8'd5, 7'd0);
    // zero id and zero size both refuse without touching the map
    send_cmd(OP_CREATE, 8'd0, 7'd4);
    send_cmd(OP_CREATE, 8'd3, 7'd0);
    send_cmd(OP_CREATE, 8'd7, 7'd127);
    send_cmd(OP_CREATE, 8'd7, 7'd65);
    send_cmd(OP_CREATE, 8'd1, 7'd64);
    send_cmd(OP_PRINT, 8'd0, 7'd0);
    send_cmd(OP_DELETE, 8'd1, 7'd0);
    send_cmd(OP_CREATE, 8'd255, 7'd1);
    send_cmd(OP_CREATE, 8'd2, 7'd10);
    send_cmd(OP_CREATE, 8'd255, 7'd5);
    send_cmd(OP_DELETE, 8'd255, 7'd0);
    send_cmd(OP_PRINT, 8'd0, 7'd0);
    send_cmd(OP_DELETE, 8'd0, 7'd0);
    send_cmd(OP_IGNORED, 8'd170, 7'd85);
    send_cmd(OP_CREATE, 8'd4, 7'd1);
    send_cmd(OP_CREATE, 8'd9, 7'd48);
    send_cmd(OP_CREATE, 8'd10, 7'd1);
    send_cmd(OP_PRINT, 8'd0, 7'd0);
    send_cmd(OP_DELETE, 8'd2, 7'd0);
    send_cmd(OP_DELETE, 8'd9, 7'd0);
    send_cmd(OP_DELETE, 8'd255, 7'd0);
    send_cmd(OP_DELETE, 8'd4, 7'd0);
    send_cmd(OP_PRINT, 8'd0, 7'd0);

    foreach (id_pool[i]) id_pool[i] = ID_W'($urandom_range(1, 255));
    sent = 0;
    while (sent < 210) begin
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
        send_cmd(OP_IGNORED, ID_W'($urandom_range(0, 255)), LEN_W'($urandom_range(0, 127)));
      end else begin
        if (pick < 45) begin
          pick = $urandom_range(0, 99);
          if (pick < 80)      sz = LEN_W'($urandom_range(1, 12));
          else if (pick < 95) sz = LEN_W'($urandom_range(13, 64));
          else                sz = LEN_W'($urandom_range(0, 127));
          send_cmd(OP_CREATE, pick_id(), sz);
        end else if (pick < 80) begin
          send_cmd(OP_DELETE, pick_id(), LEN_W'($urandom_range(0, 127)));
        end else begin
          send_cmd(OP_PRINT, ID_W'($urandom_range(0, 255)), LEN_W'($urandom_range(0, 127)));
        end
        sent++;
      end
    end

    start_i <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (2 * POOL + 8) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
